### design/etfp_pkg.sv
// Shared types, constants and helpers for the escape-time fractal pixel unit.
// Used by every module of the block and by its port checker; depends on nothing.
package etfp_pkg;

	// Number format of c and z: signed fixed point.
	localparam int NUM_W      = 32;
	localparam int FRAC_BITS  = 28;
	localparam int COORD_BITS = 12;

	// Field widths of the ports.
	localparam int PIX_W      = 12;
	localparam int STEP_W     = 31;
	localparam int BAIL_W     = 31;
	localparam int ITER_W     = 16;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Internal widths.
	localparam int PROD_W    = 2 * NUM_W;
	localparam int FOLD_W    = PROD_W + 3;
	localparam int SHIFT_W   = FOLD_W - FRAC_BITS;
	localparam int CPROD_W   = STEP_W + COORD_BITS;
	localparam int CSUM_W    = ((CPROD_W > NUM_W) ? CPROD_W : NUM_W) + 2;
	localparam int SAT_W     = (SHIFT_W > CSUM_W) ? SHIFT_W : CSUM_W;
	localparam int DIV_W     = ITER_W + CH_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};
	localparam int SECTORS = 6;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_IM       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_IM      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAILOUT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_LENGTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRACTAL_MODE = 3'd7;

	// Reset values of the registers.
	localparam logic [NUM_W-1:0]  RST_MIN_RE       = 32'hE000_0000;
	localparam logic [NUM_W-1:0]  RST_MIN_IM       = 32'hF000_0000;
	localparam logic [STEP_W-1:0] RST_STEP_RE      = 31'd786432;
	localparam logic [STEP_W-1:0] RST_STEP_IM      = 31'd524288;
	localparam logic [BAIL_W-1:0] RST_BAILOUT      = 31'd1073741824;
	localparam logic [ITER_W-1:0] RST_MAX_ITER     = 16'd256;
	localparam logic [ITER_W-1:0] RST_COLOR_LENGTH = 16'd64;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [ITER_W-1:0] iter_count;
		logic              inside_res;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
	} result_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] min_re;
		logic signed [NUM_W-1:0] min_im;
		logic [STEP_W-1:0]       step_re;
		logic [STEP_W-1:0]       step_im;
		logic [BAIL_W-1:0]       bailout;
		logic [ITER_W-1:0]       max_iter;
		logic [ITER_W-1:0]       color_length;
		logic                    fractal_mode;
	} cfg_t;

	// Which division of the palette computation is running.
	typedef enum logic [1:0] {
		PH_MOD,
		PH_SECTOR,
		PH_SHADE
	} div_phase_t;

	typedef struct packed {
		logic       load;
		logic       square;
		logic       eval;
		logic       div_go;
		logic       div_cap;
		div_phase_t div_sel;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic escaped;
		logic at_limit;
		logic div_done;
	} dp_stat_t;

	// Clamps a two's complement value to the signed range of NUM_W bits.
	function automatic logic [NUM_W-1:0] sat_num(input logic [SAT_W-1:0] v);
		logic [SAT_W-NUM_W:0] hi_bits;
		hi_bits = v[SAT_W-1:NUM_W-1];
		if ((&hi_bits) || !(|hi_bits)) begin
			sat_num = v[NUM_W-1:0];
		end else if (v[SAT_W-1]) begin
			sat_num = {1'b1, {(NUM_W-1){1'b0}}};
		end else begin
			sat_num = {1'b0, {(NUM_W-1){1'b1}}};
		end
	endfunction

endpackage

### design/etfp_divider.sv
// Restoring divider, one quotient bit per cycle, for the palette arithmetic.
// Depends on etfp_pkg for the operand widths.
module etfp_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [etfp_pkg::DIV_W-1:0]   dividend,
	input  logic [etfp_pkg::ITER_W-1:0]  divisor,
	output logic                         done,
	output logic [etfp_pkg::DIV_W-1:0]   quotient,
	output logic [etfp_pkg::ITER_W-1:0]  remainder
);

	logic [etfp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [etfp_pkg::DIV_W-1:0]     quo_q;
	logic [etfp_pkg::ITER_W-1:0]    rem_q;
	logic [etfp_pkg::ITER_W-1:0]    dvs_q;
	logic [etfp_pkg::ITER_W:0]      shifted;
	logic [etfp_pkg::ITER_W:0]      trial;
	logic                           fits;

	always_comb begin
		shifted = {rem_q, quo_q[etfp_pkg::DIV_W-1]};
		fits    = shifted >= {1'b0, dvs_q};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q  <= etfp_pkg::DIV_CNT_W'(etfp_pkg::DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - etfp_pkg::DIV_CNT_W'(1);
			done_q <= (cnt_q == etfp_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend shifts out of the quotient register as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[etfp_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? trial[etfp_pkg::ITER_W-1:0] : shifted[etfp_pkg::ITER_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### design/etfp_datapath.sv
// Datapath: point coordinate, z = z^2 + c iteration, escape test and hue palette.
// Depends on etfp_pkg and instantiates etfp_divider.
module etfp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  etfp_pkg::cfg_t     cfg,
	input  etfp_pkg::pixel_t   pixel,
	input  etfp_pkg::dp_cmd_t  cmd,
	output etfp_pkg::dp_stat_t stat,
	output etfp_pkg::result_t  result
);

	localparam logic [2:0] SEC_RED_GREEN_UP  = 3'd0;
	localparam logic [2:0] SEC_GREEN_RED_DN  = 3'd1;
	localparam logic [2:0] SEC_GREEN_BLUE_UP = 3'd2;
	localparam logic [2:0] SEC_BLUE_GREEN_DN = 3'd3;
	localparam logic [2:0] SEC_BLUE_RED_UP   = 3'd4;

	logic [etfp_pkg::NUM_W-1:0]  c_re_q, c_im_q, z_re_q, z_im_q;
	logic [etfp_pkg::ITER_W-1:0] t_q;
	logic                        have_z_q;
	logic [etfp_pkg::PROD_W-1:0] sq_re_q, sq_im_q, cross_q;
	logic                        neg_i_q;
	logic                        inside_q;
	logic [etfp_pkg::ITER_W-1:0] rem_q;
	logic [2:0]                  sector_q;
	logic [etfp_pkg::CH_W-1:0]   up_q;
	logic                        rnz_q;
	etfp_pkg::result_t           res_q;

	// Coordinate of the point.
	logic [etfp_pkg::CPROD_W-1:0]        prod_re, prod_im;
	logic signed [etfp_pkg::CSUM_W-1:0]  csum_re, csum_im;
	logic [etfp_pkg::NUM_W-1:0]          c_re_load, c_im_load;

	always_comb begin
		prod_re = etfp_pkg::CPROD_W'(cfg.step_re)
			* etfp_pkg::CPROD_W'(pixel.pixel_x[etfp_pkg::COORD_BITS-1:0]);
		prod_im = etfp_pkg::CPROD_W'(cfg.step_im)
			* etfp_pkg::CPROD_W'(pixel.pixel_y[etfp_pkg::COORD_BITS-1:0]);
		csum_re = $signed({{(etfp_pkg::CSUM_W-etfp_pkg::NUM_W){cfg.min_re[etfp_pkg::NUM_W-1]}},
			cfg.min_re}) + $signed({{(etfp_pkg::CSUM_W-etfp_pkg::CPROD_W){1'b0}}, prod_re});
		csum_im = $signed({{(etfp_pkg::CSUM_W-etfp_pkg::NUM_W){cfg.min_im[etfp_pkg::NUM_W-1]}},
			cfg.min_im}) + $signed({{(etfp_pkg::CSUM_W-etfp_pkg::CPROD_W){1'b0}}, prod_im});
		c_re_load = etfp_pkg::sat_num(etfp_pkg::SAT_W'(csum_re));
		c_im_load = etfp_pkg::sat_num(etfp_pkg::SAT_W'(csum_im));
	end

	// Magnitudes of z for the squaring stage.
	logic [etfp_pkg::NUM_W-1:0] mag_re, mag_im;

	always_comb begin
		mag_re = z_re_q[etfp_pkg::NUM_W-1] ? (~z_re_q + etfp_pkg::NUM_W'(1)) : z_re_q;
		mag_im = z_im_q[etfp_pkg::NUM_W-1] ? (~z_im_q + etfp_pkg::NUM_W'(1)) : z_im_q;
	end

	// Escape test on the squares of the current z, and the fold into the next z.
	logic [etfp_pkg::PROD_W:0]            mag_sum, limit;
	logic                                 escaped;
	logic [etfp_pkg::ITER_W-1:0]          t_next;
	logic signed [etfp_pkg::FOLD_W-1:0]   c_re_ext, c_im_ext, cross_x2, f_re, f_im;
	logic signed [etfp_pkg::SHIFT_W-1:0]  q_re, q_im;
	logic [etfp_pkg::NUM_W-1:0]           new_re, new_im;

	always_comb begin
		mag_sum = {1'b0, sq_re_q} + {1'b0, sq_im_q};
		limit   = {{(etfp_pkg::PROD_W+1-etfp_pkg::BAIL_W-etfp_pkg::FRAC_BITS){1'b0}},
			cfg.bailout, {etfp_pkg::FRAC_BITS{1'b0}}};
		escaped = mag_sum > limit;
		t_next  = have_z_q ? (t_q + etfp_pkg::ITER_W'(1)) : t_q;

		c_re_ext = {{(etfp_pkg::FOLD_W-etfp_pkg::NUM_W-etfp_pkg::FRAC_BITS)
			{c_re_q[etfp_pkg::NUM_W-1]}}, c_re_q, {etfp_pkg::FRAC_BITS{1'b0}}};
		c_im_ext = {{(etfp_pkg::FOLD_W-etfp_pkg::NUM_W-etfp_pkg::FRAC_BITS)
			{c_im_q[etfp_pkg::NUM_W-1]}}, c_im_q, {etfp_pkg::FRAC_BITS{1'b0}}};
		cross_x2 = {{(etfp_pkg::FOLD_W-etfp_pkg::PROD_W-1){1'b0}}, cross_q, 1'b0};

		// Dropping the low fraction bits of the exact sum floors it.
		f_re = $signed({{(etfp_pkg::FOLD_W-etfp_pkg::PROD_W){1'b0}}, sq_re_q})
			- $signed({{(etfp_pkg::FOLD_W-etfp_pkg::PROD_W){1'b0}}, sq_im_q}) + c_re_ext;
		f_im = (neg_i_q ? -cross_x2 : cross_x2) + c_im_ext;
		q_re = f_re[etfp_pkg::FOLD_W-1:etfp_pkg::FRAC_BITS];
		q_im = f_im[etfp_pkg::FOLD_W-1:etfp_pkg::FRAC_BITS];
		new_re = etfp_pkg::sat_num(etfp_pkg::SAT_W'(q_re));
		new_im = etfp_pkg::sat_num(etfp_pkg::SAT_W'(q_im));
	end

	// Shared divider for the palette.
	logic [etfp_pkg::DIV_W-1:0]  div_dividend, div_quo;
	logic [etfp_pkg::ITER_W-1:0] div_divisor, div_rem;
	logic                        div_done;

	always_comb begin
		div_divisor = (cfg.color_length == '0) ? etfp_pkg::ITER_W'(1) : cfg.color_length;
		case (cmd.div_sel)
			etfp_pkg::PH_MOD: begin
				div_dividend = etfp_pkg::DIV_W'(t_q);
			end
			etfp_pkg::PH_SECTOR: begin
				div_dividend = etfp_pkg::DIV_W'(rem_q) * etfp_pkg::DIV_W'(etfp_pkg::SECTORS);
			end
			default: begin
				div_dividend = etfp_pkg::DIV_W'(rem_q) * etfp_pkg::DIV_W'(etfp_pkg::CH_MAX);
			end
		endcase
	end

	etfp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (cmd.div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Hue channels from the sector and the shade fraction.
	logic [etfp_pkg::CH_W-1:0] down, red_n, green_n, blue_n;

	always_comb begin
		down    = etfp_pkg::CH_MAX - up_q - etfp_pkg::CH_W'(rnz_q);
		red_n   = '0;
		green_n = '0;
		blue_n  = '0;
		if (!inside_q) begin
			case (sector_q)
				SEC_RED_GREEN_UP: begin
					red_n   = etfp_pkg::CH_MAX;
					green_n = up_q;
				end
				SEC_GREEN_RED_DN: begin
					red_n   = down;
					green_n = etfp_pkg::CH_MAX;
				end
				SEC_GREEN_BLUE_UP: begin
					green_n = etfp_pkg::CH_MAX;
					blue_n  = up_q;
				end
				SEC_BLUE_GREEN_DN: begin
					green_n = down;
					blue_n  = etfp_pkg::CH_MAX;
				end
				SEC_BLUE_RED_UP: begin
					red_n  = up_q;
					blue_n = etfp_pkg::CH_MAX;
				end
				default: begin
					red_n  = etfp_pkg::CH_MAX;
					blue_n = down;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_re_q   <= c_re_load;
			c_im_q   <= c_im_load;
			z_re_q   <= '0;
			z_im_q   <= '0;
			t_q      <= '0;
			have_z_q <= 1'b0;
		end
		if (cmd.square) begin
			sq_re_q <= etfp_pkg::PROD_W'(mag_re) * etfp_pkg::PROD_W'(mag_re);
			sq_im_q <= etfp_pkg::PROD_W'(mag_im) * etfp_pkg::PROD_W'(mag_im);
			cross_q <= etfp_pkg::PROD_W'(mag_re) * etfp_pkg::PROD_W'(mag_im);
			neg_i_q <= !cfg.fractal_mode
				&& (z_re_q[etfp_pkg::NUM_W-1] != z_im_q[etfp_pkg::NUM_W-1]);
		end
		if (cmd.eval) begin
			inside_q <= !escaped;
			// On escape the count keeps the iterations completed before it.
			if (!escaped) begin
				t_q      <= t_next;
				have_z_q <= 1'b1;
				z_re_q   <= new_re;
				z_im_q   <= new_im;
			end
		end
		if (cmd.div_cap) begin
			case (cmd.div_sel)
				etfp_pkg::PH_MOD: begin
					rem_q <= div_rem;
				end
				etfp_pkg::PH_SECTOR: begin
					sector_q <= div_quo[2:0];
					rem_q    <= div_rem;
				end
				default: begin
					up_q  <= div_quo[etfp_pkg::CH_W-1:0];
					rnz_q <= |div_rem;
				end
			endcase
		end
		if (cmd.finish) begin
			res_q.iter_count <= t_q;
			res_q.inside_res <= inside_q;
			res_q.red        <= red_n;
			res_q.green      <= green_n;
			res_q.blue       <= blue_n;
		end
	end

	assign stat.escaped  = escaped;
	assign stat.at_limit = (t_next == cfg.max_iter);
	assign stat.div_done = div_done;
	assign result        = res_q;

endmodule

### design/etfp_ctrl.sv
// Controller: sequences coordinate load, squaring, escape test and palette divisions.
// Depends on etfp_pkg for the command and status types.
module etfp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  etfp_pkg::dp_stat_t stat,
	output etfp_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_EVAL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} state_t;

	state_t               state_q;
	etfp_pkg::div_phase_t phase_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= etfp_pkg::PH_MOD;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stat.escaped) begin
						phase_q <= etfp_pkg::PH_MOD;
						state_q <= S_DIV_GO;
					end else if (stat.at_limit) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SQUARE;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						case (phase_q)
							etfp_pkg::PH_MOD: begin
								phase_q <= etfp_pkg::PH_SECTOR;
								state_q <= S_DIV_GO;
							end
							etfp_pkg::PH_SECTOR: begin
								phase_q <= etfp_pkg::PH_SHADE;
								state_q <= S_DIV_GO;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.square  = (state_q == S_SQUARE);
		cmd.eval    = (state_q == S_EVAL);
		cmd.div_go  = (state_q == S_DIV_GO);
		cmd.div_cap = (state_q == S_DIV_WAIT) && stat.div_done;
		cmd.div_sel = phase_q;
		cmd.finish  = (state_q == S_FINISH);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### design/escape_time_fractal_pixel_unit.sv
// Escape-time fractal pixel unit: one pixel in, iteration count and hue color out.
// Each iteration has two steps, square and then test and fold; an escaping point
// then passes through three palette divisions (24 steps each) before its result.
// One item at a time; the next start is taken in the cycle that done is high.
// Reset restores the default view and clears the controller; results are not stalled.
module escape_time_fractal_pixel_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  etfp_pkg::pixel_t                pixel,
	output logic                            busy,
	output logic                            done,
	output etfp_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [etfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [etfp_pkg::CFG_DATA_W-1:0] cfg_data
);

	etfp_pkg::cfg_t     cfg_q;
	etfp_pkg::dp_cmd_t  cmd;
	etfp_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_re       <= etfp_pkg::RST_MIN_RE;
			cfg_q.min_im       <= etfp_pkg::RST_MIN_IM;
			cfg_q.step_re      <= etfp_pkg::RST_STEP_RE;
			cfg_q.step_im      <= etfp_pkg::RST_STEP_IM;
			cfg_q.bailout      <= etfp_pkg::RST_BAILOUT;
			cfg_q.max_iter     <= etfp_pkg::RST_MAX_ITER;
			cfg_q.color_length <= etfp_pkg::RST_COLOR_LENGTH;
			cfg_q.fractal_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				etfp_pkg::REG_MIN_RE:       cfg_q.min_re       <= cfg_data[etfp_pkg::NUM_W-1:0];
				etfp_pkg::REG_MIN_IM:       cfg_q.min_im       <= cfg_data[etfp_pkg::NUM_W-1:0];
				etfp_pkg::REG_STEP_RE:      cfg_q.step_re      <= cfg_data[etfp_pkg::STEP_W-1:0];
				etfp_pkg::REG_STEP_IM:      cfg_q.step_im      <= cfg_data[etfp_pkg::STEP_W-1:0];
				etfp_pkg::REG_BAILOUT:      cfg_q.bailout      <= cfg_data[etfp_pkg::BAIL_W-1:0];
				etfp_pkg::REG_MAX_ITER:     cfg_q.max_iter     <= cfg_data[etfp_pkg::ITER_W-1:0];
				etfp_pkg::REG_COLOR_LENGTH: cfg_q.color_length <= cfg_data[etfp_pkg::ITER_W-1:0];
				etfp_pkg::REG_FRACTAL_MODE: cfg_q.fractal_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	etfp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	etfp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pixel  (pixel),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

### design/etfp_checker.sv
// Port-level checker for the escape-time fractal pixel unit, bound to the top level.
// Depends on etfp_pkg for the result type.
module etfp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input etfp_pkg::result_t result
);

	// An accepted item keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted item");

	// A result is only shown once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.inside_res) |->
		(result.red == '0 && result.green == '0 && result.blue == '0))
		else $error("inside point is not black");

	// A fully saturated hue always has one channel at full scale.
	a_hue_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.inside_res) |->
		(result.red == etfp_pkg::CH_MAX || result.green == etfp_pkg::CH_MAX
		|| result.blue == etfp_pkg::CH_MAX))
		else $error("escaped point has no saturated channel");

endmodule

bind escape_time_fractal_pixel_unit etfp_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
